// ===== src/stgfc_pkg.sv =====
package stgfc_pkg;

  localparam int unsigned SETTLE_TICKS = 8;

  localparam int unsigned BadWidth = 9;
  localparam int unsigned RunonWidth = 17;

  localparam logic [BadWidth-1:0] BAD_MAX = '1;
  localparam logic [RunonWidth-1:0] RUNON_OFF = '1;

  localparam int unsigned AddrWidth = 5;

  localparam logic [2:0] REG_TEMP_LOW = 3'd0;
  localparam logic [2:0] REG_TEMP_HIGH = 3'd1;
  localparam logic [2:0] REG_CURVE_START = 3'd2;
  localparam logic [2:0] REG_FAN_POWER_BASE = 3'd3;
  localparam logic [2:0] REG_FAN_POWER_SLOPE = 3'd4;
  localparam logic [2:0] REG_FAN_POWER_LASER_MODE = 3'd5;
  localparam logic [2:0] REG_RUNON_DELAY = 3'd6;
  localparam logic [2:0] REG_FAN_PRESENT = 3'd7;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_OPEN  = 2'd1,
    FAULT_RANGE = 2'd2
  } fault_t;

  typedef enum logic [1:0] {
    ACTION_NONE = 2'd0,
    ACTION_ON   = 2'd1,
    ACTION_OFF  = 2'd2
  } action_t;

  typedef struct packed {
    logic signed [15:0] reading;
    logic               reading_valid;
    logic               laser_active;
    logic               system_halted;
  } request_t;

  typedef struct packed {
    fault_t             fault;
    action_t            fan_action;
    logic [15:0]        fan_power;
    logic signed [15:0] held_reading;
    logic               reading_seen;
  } result_t;

  typedef struct packed {
    logic signed [15:0] temp_low;
    logic signed [15:0] temp_high;
    logic signed [15:0] curve_start;
    logic [15:0]        fan_power_base;
    logic [15:0]        fan_power_slope;
    logic [15:0]        fan_power_laser_mode;
    logic [15:0]        runon_delay;
    logic               fan_present;
  } cfg_t;

  typedef struct packed {
    logic [BadWidth-1:0]   bad_count;
    logic [RunonWidth-1:0] runon_count;
    logic signed [15:0]    last_temp;
    logic                  seen_valid;
  } guard_state_t;

endpackage

// ===== src/stgfc_regs.sv =====
module stgfc_regs
  import stgfc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  cfg_t cfg_q;
  logic wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign idx = paddr[AddrWidth-1:2];
  assign cfg = cfg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.temp_low <= 16'sd0;
      cfg_q.temp_high <= 16'sd4800;
      cfg_q.curve_start <= 16'sd560;
      cfg_q.fan_power_base <= 16'd800;
      cfg_q.fan_power_slope <= 16'd160;
      cfg_q.fan_power_laser_mode <= 16'd1280;
      cfg_q.runon_delay <= 16'd180;
      cfg_q.fan_present <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_TEMP_LOW: cfg_q.temp_low <= pwdata[15:0];
        REG_TEMP_HIGH: cfg_q.temp_high <= pwdata[15:0];
        REG_CURVE_START: cfg_q.curve_start <= pwdata[15:0];
        REG_FAN_POWER_BASE: cfg_q.fan_power_base <= pwdata[15:0];
        REG_FAN_POWER_SLOPE: cfg_q.fan_power_slope <= pwdata[15:0];
        REG_FAN_POWER_LASER_MODE: cfg_q.fan_power_laser_mode <= pwdata[15:0];
        REG_RUNON_DELAY: cfg_q.runon_delay <= pwdata[15:0];
        REG_FAN_PRESENT: cfg_q.fan_present <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TEMP_LOW: prdata = {{16{cfg_q.temp_low[15]}}, cfg_q.temp_low};
      REG_TEMP_HIGH: prdata = {{16{cfg_q.temp_high[15]}}, cfg_q.temp_high};
      REG_CURVE_START: prdata = {{16{cfg_q.curve_start[15]}}, cfg_q.curve_start};
      REG_FAN_POWER_BASE: prdata = {16'd0, cfg_q.fan_power_base};
      REG_FAN_POWER_SLOPE: prdata = {16'd0, cfg_q.fan_power_slope};
      REG_FAN_POWER_LASER_MODE: prdata = {16'd0, cfg_q.fan_power_laser_mode};
      REG_RUNON_DELAY: prdata = {16'd0, cfg_q.runon_delay};
      REG_FAN_PRESENT: prdata = {31'd0, cfg_q.fan_present};
      default: prdata = 32'd0;
    endcase
  end

endmodule

// ===== src/stgfc_eval.sv =====
module stgfc_eval
  import stgfc_pkg::*;
(
  input  request_t     req,
  input  cfg_t         cfg,
  input  guard_state_t st,
  output guard_state_t st_next,
  output result_t      res
);

  logic [BadWidth-1:0]   bad_inc;
  logic                  out_of_range;
  logic signed [16:0]    diff_s;
  logic [15:0]           diff;
  logic [31:0]           prod;
  logic [28:0]           curve_sum;
  logic [15:0]           curve_power;
  logic [15:0]           power;
  logic [RunonWidth-1:0] runon_inc;
  logic [RunonWidth-1:0] delay_ext;

  assign bad_inc = (st.bad_count == BAD_MAX) ? st.bad_count : st.bad_count + 1'b1;
  assign out_of_range = (req.reading < cfg.temp_low) || (req.reading > cfg.temp_high);

  assign diff_s = {req.reading[15], req.reading} - {cfg.curve_start[15], cfg.curve_start};
  assign diff = diff_s[15:0];
  assign prod = diff * cfg.fan_power_slope;
  assign curve_sum = {13'd0, cfg.fan_power_base} + {1'b0, prod[31:4]};
  assign curve_power = (|curve_sum[28:16]) ? 16'hFFFF : curve_sum[15:0];

  always_comb begin
    if (req.laser_active) begin
      power = cfg.fan_power_laser_mode;
    end else if (!diff_s[16]) begin
      power = curve_power;
    end else begin
      power = 16'd0;
    end
  end

  assign delay_ext = {1'b0, cfg.runon_delay};
  assign runon_inc = st.runon_count + 1'b1;

  always_comb begin
    st_next = st;
    res.fault = FAULT_NONE;
    res.fan_action = ACTION_NONE;
    res.fan_power = 16'd0;
    if (!req.reading_valid) begin
      if (!req.system_halted) begin
        st_next.bad_count = bad_inc;
        if (bad_inc > BadWidth'(SETTLE_TICKS)) begin
          res.fault = FAULT_OPEN;
        end
      end
    end else begin
      st_next.bad_count = '0;
      st_next.last_temp = req.reading;
      st_next.seen_valid = 1'b1;
      if (!req.system_halted && out_of_range) begin
        res.fault = FAULT_RANGE;
      end else if (cfg.fan_present) begin
        if (power != 16'd0) begin
          st_next.runon_count = '0;
          res.fan_action = ACTION_ON;
          res.fan_power = power;
        end else if (st.runon_count <= delay_ext) begin
          st_next.runon_count = runon_inc;
          if (runon_inc > delay_ext) begin
            res.fan_action = ACTION_OFF;
          end
        end
      end
    end
    res.held_reading = st_next.last_temp;
    res.reading_seen = st_next.seen_valid;
  end

endmodule

// ===== src/spindle_temp_guard_fan_curve.sv =====
// An accepted request is held in the input register and then evaluated into
// the result register. Throughput: one request per cycle unless result_stall
// holds a full result register; the input register refills while the result
// register drains, and the fan curve multiply sits between them.
// Reset (rst, synchronous, active high) empties both registers, restores the
// configuration defaults and puts the fan run-on counter in its off state.
module spindle_temp_guard_fan_curve
  import stgfc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 request_valid,
  output logic                 request_stall,
  input  request_t             request,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  cfg_t         cfg;
  request_t     req_q;
  logic         req_full;
  logic         advance;
  logic         take;
  guard_state_t st;
  guard_state_t st_next;
  result_t      res_next;

  stgfc_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  stgfc_eval u_eval (
    .req    (req_q),
    .cfg    (cfg),
    .st     (st),
    .st_next(st_next),
    .res    (res_next)
  );

  assign advance = req_full && (!result_valid || !result_stall);
  assign request_stall = req_full && !advance;
  assign take = request_valid && !request_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (take) begin
      req_full <= 1'b1;
    end else if (advance) begin
      req_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_q <= request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.bad_count <= '0;
      st.runon_count <= RUNON_OFF;
      st.last_temp <= 16'sd0;
      st.seen_valid <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res_next;
    end
  end

`ifndef ASSERT_OFF
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    request_stall |-> req_full)
    else $error("request stalled with empty input register");

  a_advance_fills_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("result register not loaded after advance");

  a_on_clears_runon: assert property (@(posedge clk) disable iff (rst)
    (advance && res_next.fan_action == ACTION_ON) |=> (st.runon_count == '0))
    else $error("run-on counter not cleared after fan on");

  a_valid_clears_bad: assert property (@(posedge clk) disable iff (rst)
    (advance && req_q.reading_valid) |=> (st.bad_count == '0))
    else $error("settle counter not cleared by valid reading");

  a_open_needs_count: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.fault == FAULT_OPEN) |->
      (st.bad_count > BadWidth'(SETTLE_TICKS)))
    else $error("sensor-open fault below settle count");
`endif

endmodule
